// ===== rtl/cmap_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package cmap_pkg;

  // Storage sizes of the subtable.
  localparam int unsigned MAX_SEGMENTS = 64;
  localparam int unsigned GLYPH_WORDS  = 1024;

  // Fixed field widths.
  localparam int unsigned WORD_W      = 16;
  localparam int unsigned ENTRY_W     = 10;
  localparam int unsigned COUNT_W     = 7;
  localparam int unsigned GLYPH_OUT_W = 17;
  localparam int unsigned ACTION_W    = 2;
  localparam int unsigned STATUS_W    = 2;

  // Widths that follow from the storage sizes.
  localparam int unsigned SEG_IDX_W = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int unsigned CNT_W     = ($clog2(MAX_SEGMENTS + 1) > COUNT_W) ?
                                      $clog2(MAX_SEGMENTS + 1) : COUNT_W;
  localparam int unsigned GA_W      = (GLYPH_WORDS > 1) ? $clog2(GLYPH_WORDS) : 1;
  // Signed glyph array index: half offset plus code distance, less the segment term.
  localparam int unsigned IDX_W     = ((CNT_W > WORD_W + 1) ? CNT_W : WORD_W + 1) + 1;

  typedef enum logic [ACTION_W-1:0] {
    ACT_SEG_WR   = 2'd0,
    ACT_GLYPH_WR = 2'd1,
    ACT_LOOKUP   = 2'd2,
    ACT_NONE     = 2'd3
  } action_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_MAPPED     = 2'd0,
    ST_NO_SEGMENT = 2'd1,
    ST_BAD_INDEX  = 2'd2,
    ST_WRITE_DONE = 2'd3
  } status_e;

  // Item travelling along the segment chain. The four data words are shared:
  // a segment write carries first, last, delta and offset; a glyph write
  // carries the word in d0; a lookup carries the code in d0 and, once a
  // segment has hit, that segment's first code, delta and offset in d1..d3.
  typedef struct packed {
    action_e              act;
    logic [ENTRY_W-1:0]   idx;
    logic                 hit;
    logic [SEG_IDX_W-1:0] seg;
    logic [WORD_W-1:0]    d0;
    logic [WORD_W-1:0]    d1;
    logic [WORD_W-1:0]    d2;
    logic [WORD_W-1:0]    d3;
  } tok_t;

endpackage

`default_nettype wire

// ===== rtl/cmap_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module cmap_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                             clk_i,
  input  wire logic                             we_i,
  input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                 wdata_i,
  input  wire logic                             re_i,
  input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                 rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/cmap_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

module cmap_cell (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           adv_i,
  input  wire logic [cmap_pkg::SEG_IDX_W-1:0] cell_idx_i,
  input  wire logic [cmap_pkg::CNT_W-1:0]     seg_limit_i,
  input  wire logic                           vld_i,
  input  wire cmap_pkg::tok_t                 tok_i,
  output logic                                vld_o,
  output cmap_pkg::tok_t                      tok_o
);

  import cmap_pkg::*;

  logic [WORD_W-1:0] first_q;
  logic [WORD_W-1:0] last_q;
  logic [WORD_W-1:0] delta_q;
  logic [WORD_W-1:0] offset_q;
  logic              vld_q;
  tok_t              tok_q;
  tok_t              tok_d;
  logic              seg_wr;
  logic              in_range;
  logic              hit_here;

  // A segment write addressed to this cell loads its segment.
  assign seg_wr = vld_i && (tok_i.act == ACT_SEG_WR) &&
                  (tok_i.idx == ENTRY_W'(cell_idx_i));

  // The segment takes part only if it lies below the active segment count.
  assign in_range = (CNT_W'(cell_idx_i) < seg_limit_i) &&
                    (tok_i.d0 >= first_q) && (tok_i.d0 <= last_q);

  // Earlier cells have priority: only a lookup not yet hit may claim this one.
  assign hit_here = vld_i && (tok_i.act == ACT_LOOKUP) && !tok_i.hit && in_range;

  always_comb begin
    tok_d = tok_i;
    if (hit_here) begin
      tok_d.hit = 1'b1;
      tok_d.seg = cell_idx_i;
      tok_d.d1  = first_q;
      tok_d.d2  = delta_q;
      tok_d.d3  = offset_q;
    end
  end

  // Item valid flag towards the next cell.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (adv_i) begin
      vld_q <= vld_i;
    end
  end

  // Item payload and segment storage.
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      tok_q <= tok_d;
      if (seg_wr) begin
        first_q  <= tok_i.d0;
        last_q   <= tok_i.d1;
        delta_q  <= tok_i.d2;
        offset_q <= tok_i.d3;
      end
    end
  end

  assign vld_o = vld_q;
  assign tok_o = tok_q;

endmodule

`default_nettype wire

// ===== rtl/char_code_to_glyph_segment_map_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Character code to glyph mapping through one segment-mapping subtable.
// Items enter on the in_valid_i / in_ready_o channel; every item gives one
// result on the out_valid_o / out_ready_i channel, in order. An item either
// loads a segment, loads a glyph array word, or looks up a code.
// Items walk a chain of one cell per segment slot, one cell per cycle while not stalled, so
// writes and lookups keep their order without any hazard checks. After the
// chain, one stage forms the glyph array index and reads the glyph memory,
// and one stage registers the result.
// Throughput: one item per cycle while results are taken; the whole chain moves together.
// When the receiver stalls with a result waiting, the chain freezes and
// in_ready_o drops in the same cycle; nothing is lost or repeated.
// Reset empties the chain and sets the segment count to one. Segment and
// glyph storage is not cleared and must be loaded before it is looked up.
// The user must write the segment count via cfg_we_i only while no item is in flight (not enforced).
module char_code_to_glyph_segment_map_unit (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_we_i,
  input  wire logic [cmap_pkg::COUNT_W-1:0]       cfg_wdata_i,
  input  wire logic                               in_valid_i,
  output logic                                    in_ready_o,
  input  wire logic [cmap_pkg::ACTION_W-1:0]      action_i,
  input  wire logic [cmap_pkg::ENTRY_W-1:0]       entry_index_i,
  input  wire logic [cmap_pkg::WORD_W-1:0]        first_code_i,
  input  wire logic [cmap_pkg::WORD_W-1:0]        last_code_i,
  input  wire logic [cmap_pkg::WORD_W-1:0]        delta_i,
  input  wire logic [cmap_pkg::WORD_W-1:0]        range_offset_i,
  input  wire logic [cmap_pkg::WORD_W-1:0]        glyph_word_i,
  input  wire logic [cmap_pkg::WORD_W-1:0]        code_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_ready_i,
  output logic signed [cmap_pkg::GLYPH_OUT_W-1:0] glyph_out_o,
  output logic [cmap_pkg::STATUS_W-1:0]           status_o
);

  import cmap_pkg::*;

  typedef struct packed {
    status_e           st;
    logic              use_ram;
    logic [WORD_W-1:0] glyph;
    logic [WORD_W-1:0] delta;
  } res_t;

  logic [COUNT_W-1:0]           seg_count_q;
  logic [CNT_W-1:0]             seg_limit;
  logic                         adv;
  logic                         chain_vld [MAX_SEGMENTS+1];
  tok_t                         chain_tok [MAX_SEGMENTS+1];
  tok_t                         in_tok;
  action_e                      in_act;
  tok_t                         tail;
  logic                         tail_vld;
  logic [WORD_W-1:0]            code_off;
  logic [WORD_W:0]              idx_pos;
  logic [CNT_W-1:0]             idx_neg;
  logic signed [IDX_W-1:0]      idx_s;
  logic                         idx_bad;
  res_t                         r_d;
  res_t                         r_q;
  logic                         r_vld_q;
  logic                         ram_we;
  logic                         ram_re;
  logic [WORD_W-1:0]            ram_rdata;
  logic [WORD_W-1:0]            glyph_fin;
  logic [GLYPH_OUT_W-1:0]       glyph_d;
  logic                         out_vld_q;
  logic [GLYPH_OUT_W-1:0]       glyph_q;
  status_e                      status_q;

  // Segment count register; counts beyond the storage use every slot.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_count_q <= COUNT_W'(1);
    end else if (cfg_we_i) begin
      seg_count_q <= cfg_wdata_i;
    end
  end

  assign seg_limit = (CNT_W'(seg_count_q) > CNT_W'(MAX_SEGMENTS)) ?
                     CNT_W'(MAX_SEGMENTS) : CNT_W'(seg_count_q);

  // The whole chain moves whenever the output register can take a result.
  assign adv        = !out_vld_q || out_ready_i;
  assign in_ready_o = adv;

  // Pack the incoming item into the shared data words.
  assign in_act = action_e'(action_i);

  always_comb begin
    in_tok     = '0;
    in_tok.act = in_act;
    in_tok.idx = entry_index_i;
    in_tok.hit = 1'b0;
    case (in_act)
      ACT_SEG_WR: begin
        in_tok.d0 = first_code_i;
        in_tok.d1 = last_code_i;
        in_tok.d2 = delta_i;
        in_tok.d3 = range_offset_i;
      end
      ACT_GLYPH_WR: begin
        in_tok.d0 = glyph_word_i;
      end
      ACT_LOOKUP: begin
        in_tok.d0 = code_i;
      end
      default: begin
        in_tok.d0 = '0;
      end
    endcase
  end

  assign chain_vld[0] = in_valid_i;
  assign chain_tok[0] = in_tok;

  // One cell per segment slot, searched in slot order along the chain.
  for (genvar k = 0; k < MAX_SEGMENTS; k++) begin : g_cell
    cmap_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .adv_i       (adv),
      .cell_idx_i  (SEG_IDX_W'(k)),
      .seg_limit_i (seg_limit),
      .vld_i       (chain_vld[k]),
      .tok_i       (chain_tok[k]),
      .vld_o       (chain_vld[k+1]),
      .tok_o       (chain_tok[k+1])
    );
  end

  assign tail_vld = chain_vld[MAX_SEGMENTS];
  assign tail     = chain_tok[MAX_SEGMENTS];

  // Glyph array index: offset/2 - (count - segment) + (code - first code).
  assign code_off = tail.d0 - tail.d1;
  assign idx_pos  = {2'b00, tail.d3[WORD_W-1:1]} + {1'b0, code_off};
  assign idx_neg  = seg_limit - CNT_W'(tail.seg);
  assign idx_s    = $signed(IDX_W'(idx_pos)) - $signed(IDX_W'(idx_neg));
  assign idx_bad  = idx_s[IDX_W-1] || (idx_s >= $signed(IDX_W'(GLYPH_WORDS)));

  // Resolve everything that does not need the glyph memory.
  always_comb begin
    r_d         = '0;
    r_d.st      = ST_WRITE_DONE;
    r_d.use_ram = 1'b0;
    r_d.delta   = tail.d2;
    r_d.glyph   = tail.d2 + tail.d0;
    if (tail.act == ACT_LOOKUP) begin
      if (!tail.hit) begin
        r_d.st = ST_NO_SEGMENT;
      end else if (tail.d3 == '0) begin
        r_d.st = ST_MAPPED;
      end else if (idx_bad) begin
        r_d.st = ST_BAD_INDEX;
      end else begin
        r_d.st      = ST_MAPPED;
        r_d.use_ram = 1'b1;
      end
    end
  end

  assign ram_we = adv && tail_vld && (tail.act == ACT_GLYPH_WR) &&
                  ({{(WORD_W + 1 - ENTRY_W){1'b0}}, tail.idx} < (WORD_W + 1)'(GLYPH_WORDS));
  assign ram_re = adv && tail_vld && r_d.use_ram;

  cmap_ram #(
    .WIDTH (WORD_W),
    .DEPTH (GLYPH_WORDS)
  ) u_glyph_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (GA_W'(tail.idx)),
    .wdata_i (tail.d0),
    .re_i    (ram_re),
    .raddr_i (idx_s[GA_W-1:0]),
    .rdata_o (ram_rdata)
  );

  // Memory stage control and payload.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_vld_q <= 1'b0;
    end else if (adv) begin
      r_vld_q <= tail_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      r_q <= r_d;
    end
  end

  // A zero glyph word gives zero, else delta is added; a mapped result is then less one, others zero.
  always_comb begin
    glyph_fin = r_q.glyph;
    if (r_q.use_ram) begin
      glyph_fin = (ram_rdata != '0) ? (ram_rdata + r_q.delta) : '0;
    end
    glyph_d = (r_q.st == ST_MAPPED) ?
              ({1'b0, glyph_fin} - GLYPH_OUT_W'(1)) : '0;
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= r_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      glyph_q  <= glyph_d;
      status_q <= r_q.st;
    end
  end

  assign out_valid_o = out_vld_q;
  assign glyph_out_o = $signed(glyph_q);
  assign status_o    = status_q;

  // Only a mapped result carries a glyph.
  a_unmapped_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o != ST_MAPPED)) |-> (glyph_out_o == '0))
    else $error("unmapped result with nonzero glyph");

  // A result that needs the glyph memory always ends up mapped.
  a_ram_mapped : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && r_vld_q && r_q.use_ram) |=> (out_valid_o && (status_o == ST_MAPPED)))
    else $error("memory read did not produce a mapped result");

  // Anything other than a lookup leaving the chain reports a finished write.
  a_write_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && tail_vld && (tail.act != ACT_LOOKUP)) |=>
    (r_vld_q && (r_q.st == ST_WRITE_DONE) && !r_q.use_ram))
    else $error("write item did not report write done");

endmodule

`default_nettype wire
